// File: src/ups_pkg.sv
package ups_pkg;

    localparam logic [7:0] LEAD_BYTE  = 8'hE2;
    localparam logic [7:0] MID_PUNCT  = 8'h80;
    localparam logic [7:0] MID_CURR   = 8'h82;
    localparam logic [7:0] MID_ARROW  = 8'h86;
    localparam logic [7:0] LAST_EURO  = 8'hAC;
    localparam logic [7:0] LAST_LEFT  = 8'h90;
    localparam logic [7:0] LAST_RIGHT = 8'h92;

    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_GRAVE  = 8'h60;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] U8_C2     = 8'hC2;
    localparam logic [7:0] U8_C3     = 8'hC3;
    localparam logic [7:0] U8_ACUTE  = 8'hB4;
    localparam logic [7:0] U8_MIDDOT = 8'hB7;
    localparam logic [7:0] U8_TIMES  = 8'h97;
    localparam logic [7:0] U8_CURR   = 8'hA4;

    // Up to three output bytes; entry 0 goes out first.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } ups_rep_t;

    typedef struct packed {
        logic [1:0] held_count;
        logic [7:0] held_second;
    } ups_state_t;

    function automatic ups_rep_t rep1(input logic [7:0] a);
        ups_rep_t r;
        r.cnt   = 2'd1;
        r.bytes = {8'h00, 8'h00, a};
        return r;
    endfunction

    function automatic ups_rep_t rep2(input logic [7:0] a, input logic [7:0] b);
        ups_rep_t r;
        r.cnt   = 2'd2;
        r.bytes = {8'h00, b, a};
        return r;
    endfunction

    function automatic ups_rep_t rep3(input logic [7:0] a);
        ups_rep_t r;
        r.cnt   = 2'd3;
        r.bytes = {a, a, a};
        return r;
    endfunction

    // Replacement for LEAD_BYTE, mid, last; a count of zero means no match.
    function automatic ups_rep_t ups_lookup(input logic [7:0] mid, input logic [7:0] last);
        ups_rep_t r;
        r = '0;
        if (mid == MID_PUNCT)
        begin
            case (last) inside
                8'h90, 8'h91: r = rep1(CH_DASH);
                8'h92, 8'h93: r = rep2(CH_DASH, CH_DASH);
                8'h94, 8'h95: r = rep3(CH_DASH);
                8'h98:        r = rep1(CH_GRAVE);
                8'h9A:        r = rep1(CH_COMMA);
                8'h9B:        r = rep2(U8_C2, U8_ACUTE);
                8'h9C:        r = rep2(CH_APOS, CH_APOS);
                8'h9D, 8'h9F: r = rep1(CH_QUOTE);
                8'h9E:        r = rep2(CH_COMMA, CH_COMMA);
                8'hA0, 8'hA1: r = rep1(CH_PLUS);
                8'hA2, 8'hA7: r = rep2(U8_C2, U8_MIDDOT);
                8'hA5:        r = rep2(CH_DOT, CH_DOT);
                8'hA6:        r = rep3(CH_DOT);
                8'hB9:        r = rep1(CH_LT);
                8'hBA:        r = rep1(CH_GT);
                8'hBB:        r = rep2(U8_C3, U8_TIMES);
                8'hBC:        r = rep2(CH_BANG, CH_BANG);
                default:      r = '0;
            endcase
        end
        else if (mid == MID_CURR && last == LAST_EURO)
        begin
            r = rep2(U8_C2, U8_CURR);
        end
        else if (mid == MID_ARROW && last == LAST_LEFT)
        begin
            r = rep2(CH_LT, CH_DASH);
        end
        else if (mid == MID_ARROW && last == LAST_RIGHT)
        begin
            r = rep2(CH_DASH, CH_GT);
        end
        return r;
    endfunction

endpackage

// File: src/ups_in_if.sv
interface ups_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

// File: src/ups_out_if.sv
interface ups_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

// File: src/utf8_punctuation_substituter.sv
// Channel  Dir  Payload                            Handshake
// raw      in   in_byte[7:0], stream_end           valid/ready
// clean    out  out_byte[7:0], run_last, stream_done valid/ready
// cfg      in   cfg_wdata = replace_enable          cfg_we
//
// A byte is registered, decoded combinationally and its zero to three result bytes are
// loaded into the result register, which hands out one word per cycle while clean.ready
// is high. Throughput is one input byte per cycle while each byte yields at most one word
// and clean.ready stays high; a byte that yields several words holds the result register
// until its last word is taken. Reset sets replace_enable and drops any held prefix. A byte
// with no result moves on even while the result register is stalled.
module utf8_punctuation_substituter (
    input  logic      clk,
    input  logic      rst_n,
    ups_in_if.sink    raw,
    ups_out_if.source clean,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);
    import ups_pkg::*;

    logic       replace_enable_reg;
    ups_state_t state_reg;
    ups_state_t state_next;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;

    logic            res_valid_reg;
    logic [2:0][7:0] res_bytes_reg;
    logic [1:0]      res_cnt_reg;
    logic [1:0]      res_idx_reg;
    logic            res_end_reg;

    ups_rep_t rep;
    logic     run_last;
    logic     take;
    logic     res_free;
    logic     s1_fire;

    ups_step u_step (
        .replace_enable (replace_enable_reg),
        .state          (state_reg),
        .in_byte        (s1_byte_reg),
        .stream_end     (s1_end_reg),
        .state_next     (state_next),
        .rep            (rep)
    );

    assign run_last = (res_idx_reg == res_cnt_reg - 2'd1);
    assign take     = res_valid_reg && clean.ready;
    assign res_free = !res_valid_reg || (take && run_last);
    assign s1_fire  = s1_valid_reg && ((rep.cnt == 2'd0) || res_free);

    assign raw.ready         = !s1_valid_reg || s1_fire;
    assign clean.valid       = res_valid_reg;
    assign clean.out_byte    = res_bytes_reg[res_idx_reg];
    assign clean.run_last    = run_last;
    assign clean.stream_done = run_last && res_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replace_enable_reg <= 1'b1;
            state_reg          <= '0;
            s1_valid_reg       <= 1'b0;
            res_valid_reg      <= 1'b0;
            res_idx_reg        <= 2'd0;
            res_cnt_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                replace_enable_reg <= cfg_wdata;
            end

            if (raw.valid && raw.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                state_reg <= state_next;
            end

            if (s1_fire && rep.cnt != 2'd0)
            begin
                res_valid_reg <= 1'b1;
                res_cnt_reg   <= rep.cnt;
                res_idx_reg   <= 2'd0;
            end
            else if (take && run_last)
            begin
                res_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                res_idx_reg <= res_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            s1_byte_reg <= raw.in_byte;
            s1_end_reg  <= raw.stream_end;
        end
        if (s1_fire && rep.cnt != 2'd0)
        begin
            res_bytes_reg <= rep.bytes;
            res_end_reg   <= s1_end_reg;
        end
    end

    // The word index never runs past the loaded count.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_idx_reg < res_cnt_reg))
        else $error("result index beyond count");

    // Nothing stays held after the end of a stream.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_end_reg) |=> (state_reg.held_count == 2'd0))
        else $error("prefix held after stream end");

    // In bypass no prefix is kept.
    a_bypass_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !replace_enable_reg) |=> (state_reg.held_count == 2'd0))
        else $error("prefix held in bypass");

    // A stalled result keeps its word index.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !clean.ready) |=> (res_valid_reg && $stable(res_idx_reg)))
        else $error("stalled result moved");
endmodule

// File: src/ups_step.sv
module ups_step (
    input  logic                replace_enable,
    input  ups_pkg::ups_state_t state,
    input  logic [7:0]          in_byte,
    input  logic                stream_end,
    output ups_pkg::ups_state_t state_next,
    output ups_pkg::ups_rep_t   rep
);
    import ups_pkg::*;

    ups_rep_t   tbl;
    logic [1:0] hc;
    logic [7:0] hs;
    logic [1:0] n;
    logic [2:0][7:0] buf_b;
    logic       mismatch;

    assign tbl = ups_lookup(state.held_second, in_byte);

    always_comb
    begin
        hc       = state.held_count;
        hs       = state.held_second;
        n        = 2'd0;
        buf_b    = '0;
        mismatch = 1'b0;

        if (!replace_enable)
        begin
            mismatch = 1'b1;
        end
        else if (hc == 2'd0)
        begin
            mismatch = 1'b0;
        end
        else if (hc == 2'd1)
        begin
            if (in_byte == MID_PUNCT || in_byte == MID_CURR || in_byte == MID_ARROW)
            begin
                hc = 2'd2;
                hs = in_byte;
            end
            else
            begin
                mismatch = 1'b1;
            end
        end
        else if (tbl.cnt != 2'd0)
        begin
            hc    = 2'd0;
            hs    = 8'h00;
            n     = tbl.cnt;
            buf_b = tbl.bytes;
        end
        else
        begin
            mismatch = 1'b1;
        end

        // Held bytes go out unchanged, then the current byte is looked at afresh.
        if (mismatch)
        begin
            if (hc != 2'd0)
            begin
                buf_b[n] = LEAD_BYTE;
                n = n + 2'd1;
            end
            if (hc[1])
            begin
                buf_b[n] = hs;
                n = n + 2'd1;
            end
            hc = 2'd0;
            hs = 8'h00;
            if (replace_enable && in_byte == LEAD_BYTE)
            begin
                hc = 2'd1;
            end
            else
            begin
                buf_b[n] = in_byte;
                n = n + 2'd1;
            end
        end
        else if (state.held_count == 2'd0)
        begin
            if (in_byte == LEAD_BYTE)
            begin
                hc = 2'd1;
            end
            else
            begin
                buf_b[n] = in_byte;
                n = n + 2'd1;
            end
        end

        if (stream_end)
        begin
            if (hc != 2'd0)
            begin
                buf_b[n] = LEAD_BYTE;
                n = n + 2'd1;
            end
            if (hc[1])
            begin
                buf_b[n] = hs;
                n = n + 2'd1;
            end
            hc = 2'd0;
            hs = 8'h00;
        end

        state_next.held_count  = hc;
        state_next.held_second = hs;
        rep.cnt   = n;
        rep.bytes = buf_b;
    end
endmodule
